// ===== src/hsvrgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL/HSV to RGB converter package
// Field widths, transfer payload types and shared constants of the converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int HUE_W    = 15;
	localparam int SAT_W    = 8;
	localparam int LVL_W    = 8;
	localparam int CH_W     = 8;

	// Default number of fractional bits in the hue (degrees times 2^n).
	localparam int HUE_FRAC_BITS_DEF = 6;

	// Codes of the model select register.
	localparam logic MODEL_HSL = 1'b0;
	localparam logic MODEL_HSV = 1'b1;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] saturation;
		logic [LVL_W-1:0] level;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pix_out_t;

endpackage

// ===== src/hsl_hsv_to_rgb_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL/HSV to RGB converter, top level
// Converts one pixel per clock unless stalled, from hue, saturation and
// lightness or value to truncated 8-bit RGB in a fixed-point pipeline.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                      Contents
//  pix       in         pix_valid, pix_ready, pix    hue, saturation, level
//  rgb       out        rgb_valid, rgb_ready, rgb    red, green, blue
//  cfg       in         cfg_we, cfg_wdata            model select (0 HSL, 1 HSV)
//
// A pixel transfer is accepted every clock while the output side keeps up;
// its result passes through the 5 arithmetic stages, the 2 stages of the
// reciprocal divider (estimate, then remainder) and the output register,
// where the estimate is corrected and the channels placed.
// Reset clears all valid bits and selects HSL.
// When the output stalls, the item in the output register moves to a skid
// register, so one more transfer is taken before the input side stalls; the
// whole pipeline then holds until the skid register is emptied.
//
module hsl_hsv_to_rgb_converter_top #(
	parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  hsvrgb_pkg::pix_in_t  pix,
	output logic                 rgb_valid,
	input  logic                 rgb_ready,
	output hsvrgb_pkg::pix_out_t rgb,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata
);

	// One sector of the hue circle is 60 degrees, P in hue units.
	localparam int P       = 60 << HUE_FRAC_BITS;
	localparam int TWO_P   = 2 * P;
	localparam int PW      = $clog2(P + 1);
	localparam int HUE_W   = hsvrgb_pkg::HUE_W;
	localparam int CH_W    = hsvrgb_pkg::CH_W;
	localparam int HUE_MAX = (1 << HUE_W) - 1;

	// The hue is reduced modulo 2P with a reciprocal multiply. The estimate
	// is low by at most one period, which a later compare and subtract fixes.
	localparam int    L2P     = $clog2(TWO_P);
	localparam int    SH      = HUE_W + L2P;
	localparam longint RECIP  = (longint'(1) << SH) / TWO_P;
	localparam int    RECIP_W = $clog2(RECIP + 1);
	localparam int    MUL_W   = HUE_W + RECIP_W;
	localparam int    QMAX    = HUE_MAX / TWO_P;
	localparam int    QW      = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
	localparam int    RRW     = $clog2(2 * TWO_P);
	localparam int    CMP_W   = ($clog2(5 * P + 1) > HUE_W) ? $clog2(5 * P + 1) : HUE_W;

	// Chroma and offset numerators fit 17 bits; every channel numerator is
	// at most their sum times P.
	localparam int CN_W      = 2 * hsvrgb_pkg::SAT_W + 1;
	localparam int NUM_W     = CN_W + PW;

	// Since P is 60 shifted left, floor(N / (Dn*P)) equals the shifted-down
	// numerator divided by Dn*60. That numerator stays below 256*510*60, so a
	// reciprocal with as many fraction bits as it has bits gives a quotient
	// that is never high and at most one low.
	localparam int NQ_W      = $clog2(256 * 510 * 60);
	localparam int DIVQ_HSV  = 255 * 60;
	localparam int DIVQ_HSL  = 510 * 60;
	localparam int DQ_W      = $clog2(DIVQ_HSL + 1);
	localparam int RM_W      = DQ_W + 1;
	localparam int RECIP_HSV = (1 << NQ_W) / DIVQ_HSV;
	localparam int RECIP_HSL = (1 << NQ_W) / DIVQ_HSL;
	localparam int RCP_W     = $clog2(RECIP_HSV + 1);
	localparam int PRD_W     = NQ_W + RCP_W;
	localparam int NST       = 8;

	typedef enum logic [2:0] {
		SEC_RY,
		SEC_YG,
		SEC_GC,
		SEC_CB,
		SEC_BM,
		SEC_MR
	} sector_t;

	// Lanes of the divider: chroma channel, intermediate channel, zero channel.
	localparam int LANE_C = 0;
	localparam int LANE_X = 1;
	localparam int LANE_0 = 2;

	logic             model_q;
	logic [NST:1]     vld_q;
	logic             en;
	logic             skid_vld_q;
	hsvrgb_pkg::pix_out_t skid_q;

	// Stage 1 signals.
	logic [MUL_W-1:0] qprod;
	logic [CMP_W-1:0] hue_cmp;
	sector_t          sec_d;
	logic [8:0]       twol;
	logic [8:0]       absd;
	logic [7:0]       a_val;
	logic [15:0]      as_val;
	logic [15:0]      ls_val;
	logic [15:0]      lns_val;
	logic [CN_W-1:0]  cn_d;
	logic [CN_W-1:0]  mn_d;

	logic [HUE_W-1:0] hue_s1;
	logic [QW-1:0]    q_s1;
	sector_t          sec_s1;
	logic             mode_s1;
	logic [CN_W-1:0]  cn_s1;
	logic [CN_W-1:0]  mn_s1;

	logic [HUE_W-1:0] qm;
	logic [RRW-1:0]   rraw_s2;
	sector_t          sec_s2;
	logic             mode_s2;
	logic [CN_W-1:0]  cn_s2;
	logic [NUM_W-1:0] numc_s2;
	logic [NUM_W-1:0] num0_s2;

	logic [RRW-1:0]   rc;
	logic [PW-1:0]    fn_d;
	logic [PW-1:0]    fn_s3;
	sector_t          sec_s3;
	logic             mode_s3;
	logic [CN_W-1:0]  cn_s3;
	logic [NUM_W-1:0] numc_s3;
	logic [NUM_W-1:0] num0_s3;

	logic [NUM_W-1:0] prod_s4;
	sector_t          sec_s4;
	logic             mode_s4;
	logic [NUM_W-1:0] numc_s4;
	logic [NUM_W-1:0] num0_s4;

	logic [NUM_W-1:0] numx_s5;
	sector_t          sec_s5;
	logic             mode_s5;
	logic [NUM_W-1:0] numc_s5;
	logic [NUM_W-1:0] num0_s5;

	logic [2:0][NQ_W-1:0]  nq_d;
	logic [RCP_W-1:0]      rcp_d;
	logic [2:0][PRD_W-1:0] qprd_d;
	logic [2:0][CH_W-1:0]  qe_d;
	logic [2:0][NQ_W-1:0]  nq_s6;
	logic [2:0][CH_W-1:0]  qe_s6;
	sector_t               sec_s6;
	logic                  mode_s6;

	logic [DQ_W-1:0]       dq_rem;
	logic [2:0][RM_W-1:0]  rem_d;
	logic [2:0][RM_W-1:0]  rem_s7;
	logic [2:0][CH_W-1:0]  qe_s7;
	sector_t               sec_s7;
	logic                  mode_s7;

	logic [DQ_W-1:0]       dq_fix;
	logic [2:0][CH_W-1:0]  q_d;

	hsvrgb_pkg::pix_out_t out_d;
	hsvrgb_pkg::pix_out_t out_s8;

	// ------------------------------------------------------------------
	// Configuration and flow control
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= hsvrgb_pkg::MODEL_HSL;
		end else if (cfg_we) begin
			model_q <= cfg_wdata;
		end
	end

	// The pipeline moves as one whole whenever the skid register is empty.
	assign en        = !skid_vld_q;
	assign pix_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			skid_vld_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[NST-1:1], pix_valid};
				if (vld_q[NST] && !rgb_ready) begin
					skid_vld_q <= 1'b1;
				end
			end else if (rgb_ready) begin
				skid_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_q[NST] && !rgb_ready) begin
			skid_q <= out_s8;
		end
	end

	assign rgb_valid = skid_vld_q || vld_q[NST];
	assign rgb       = skid_vld_q ? skid_q : out_s8;

	// ------------------------------------------------------------------
	// Stage 1: hue period estimate, sector, chroma and offset numerators
	// ------------------------------------------------------------------
	assign qprod   = MUL_W'(pix.hue) * MUL_W'(RECIP);
	assign hue_cmp = CMP_W'(pix.hue);

	always_comb begin
		if (hue_cmp < CMP_W'(P)) begin
			sec_d = SEC_RY;
		end else if (hue_cmp < CMP_W'(2 * P)) begin
			sec_d = SEC_YG;
		end else if (hue_cmp < CMP_W'(3 * P)) begin
			sec_d = SEC_GC;
		end else if (hue_cmp < CMP_W'(4 * P)) begin
			sec_d = SEC_CB;
		end else if (hue_cmp < CMP_W'(5 * P)) begin
			sec_d = SEC_BM;
		end else begin
			sec_d = SEC_MR;
		end
	end

	// HSL: A = 255 - |2L - 255|, C = 2*A*S, M = 510*L - A*S (over 510).
	// HSV: C = V*S, M = V*(255 - S) (over 255).
	assign twol    = {pix.level, 1'b0};
	assign absd    = (twol >= 9'd255) ? (twol - 9'd255) : (9'd255 - twol);
	assign a_val   = 8'(9'd255 - absd);
	assign as_val  = 16'(a_val) * 16'(pix.saturation);
	assign ls_val  = 16'(pix.level) * 16'(pix.saturation);
	assign lns_val = 16'(pix.level) * 16'(8'd255 - pix.saturation);

	always_comb begin
		if (model_q == hsvrgb_pkg::MODEL_HSV) begin
			cn_d = CN_W'(ls_val);
			mn_d = CN_W'(lns_val);
		end else begin
			cn_d = {as_val, 1'b0};
			mn_d = CN_W'(CN_W'(pix.level) * CN_W'(510)) - CN_W'(as_val);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s1  <= pix.hue;
			q_s1    <= QW'(qprod >> SH);
			sec_s1  <= sec_d;
			mode_s1 <= model_q;
			cn_s1   <= cn_d;
			mn_s1   <= mn_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: coarse hue remainder, chroma and offset numerators times P
	// ------------------------------------------------------------------
	assign qm = HUE_W'(32'(q_s1) * 32'(TWO_P));

	always_ff @(posedge clk) begin
		if (en) begin
			rraw_s2 <= RRW'(hue_s1 - qm);
			sec_s2  <= sec_s1;
			mode_s2 <= mode_s1;
			cn_s2   <= cn_s1;
			numc_s2 <= (NUM_W'(cn_s1) + NUM_W'(mn_s1)) * NUM_W'(P);
			num0_s2 <= NUM_W'(mn_s1) * NUM_W'(P);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: exact remainder and position inside the sector pair
	// ------------------------------------------------------------------
	assign rc   = (rraw_s2 >= RRW'(TWO_P)) ? (rraw_s2 - RRW'(TWO_P)) : rraw_s2;
	assign fn_d = (rc >= RRW'(P)) ? PW'(RRW'(TWO_P) - rc) : PW'(rc);

	always_ff @(posedge clk) begin
		if (en) begin
			fn_s3   <= fn_d;
			sec_s3  <= sec_s2;
			mode_s3 <= mode_s2;
			cn_s3   <= cn_s2;
			numc_s3 <= numc_s2;
			num0_s3 <= num0_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stages 4 and 5: intermediate channel numerator C*fn + M*P
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= NUM_W'(cn_s3) * NUM_W'(fn_s3);
			sec_s4  <= sec_s3;
			mode_s4 <= mode_s3;
			numc_s4 <= numc_s3;
			num0_s4 <= num0_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s5 <= prod_s4 + num0_s4;
			sec_s5  <= sec_s4;
			mode_s5 <= mode_s4;
			numc_s5 <= numc_s4;
			num0_s5 <= num0_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: quotient estimate by reciprocal multiplication
	// ------------------------------------------------------------------
	assign nq_d[LANE_C] = NQ_W'(numc_s5 >> HUE_FRAC_BITS);
	assign nq_d[LANE_X] = NQ_W'(numx_s5 >> HUE_FRAC_BITS);
	assign nq_d[LANE_0] = NQ_W'(num0_s5 >> HUE_FRAC_BITS);
	assign rcp_d = (mode_s5 == hsvrgb_pkg::MODEL_HSV) ? RCP_W'(RECIP_HSV)
		: RCP_W'(RECIP_HSL);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qprd_d[i] = PRD_W'(nq_d[i]) * PRD_W'(rcp_d);
			qe_d[i]   = CH_W'(qprd_d[i] >> NQ_W);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nq_s6   <= nq_d;
			qe_s6   <= qe_d;
			sec_s6  <= sec_s5;
			mode_s6 <= mode_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: remainder left by the estimate, below twice the divisor
	// ------------------------------------------------------------------
	assign dq_rem = (mode_s6 == hsvrgb_pkg::MODEL_HSV) ? DQ_W'(DIVQ_HSV)
		: DQ_W'(DIVQ_HSL);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_d[i] = RM_W'(nq_s6[i] - NQ_W'(NQ_W'(qe_s6[i]) * NQ_W'(dq_rem)));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s7  <= rem_d;
			qe_s7   <= qe_s6;
			sec_s7  <= sec_s6;
			mode_s7 <= mode_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: correct the estimate, then place chroma, intermediate and
	// zero on the channels
	// ------------------------------------------------------------------
	assign dq_fix = (mode_s7 == hsvrgb_pkg::MODEL_HSV) ? DQ_W'(DIVQ_HSV)
		: DQ_W'(DIVQ_HSL);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q_d[i] = (rem_s7[i] >= RM_W'(dq_fix)) ? (qe_s7[i] + CH_W'(1)) : qe_s7[i];
		end
	end

	always_comb begin
		case (sec_s7)
			SEC_RY: out_d = '{red: q_d[LANE_C], green: q_d[LANE_X], blue: q_d[LANE_0]};
			SEC_YG: out_d = '{red: q_d[LANE_X], green: q_d[LANE_C], blue: q_d[LANE_0]};
			SEC_GC: out_d = '{red: q_d[LANE_0], green: q_d[LANE_C], blue: q_d[LANE_X]};
			SEC_CB: out_d = '{red: q_d[LANE_0], green: q_d[LANE_X], blue: q_d[LANE_C]};
			SEC_BM: out_d = '{red: q_d[LANE_X], green: q_d[LANE_0], blue: q_d[LANE_C]};
			default: out_d = '{red: q_d[LANE_C], green: q_d[LANE_0], blue: q_d[LANE_X]};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s8 <= out_d;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// While the skid register is full, nothing in the pipeline moves.
	a_skid_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |=> $stable(vld_q))
		else $error("pipeline advanced while the skid register was full");

	// The skid register only fills from a stalled output register.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(vld_q[NST] && !rgb_ready))
		else $error("skid register filled without an output stall");

	// The reciprocal estimate is never more than one below the quotient.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[7] |-> (rem_s7[LANE_C] < {dq_fix, 1'b0}
			&& rem_s7[LANE_X] < {dq_fix, 1'b0}
			&& rem_s7[LANE_0] < {dq_fix, 1'b0}))
		else $error("divider remainder out of range");

	// The intermediate term never exceeds the chroma channel.
	a_x_le_c: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[5] |-> numx_s5 <= numc_s5)
		else $error("intermediate numerator above chroma numerator");

endmodule
